// ----- hdl/hsic_pkg.sv -----
// Shared constants and types for the centered-trace block.
package hsic_pkg;

  localparam int MaxSize    = 64;
  localparam int SizeW      = 7;
  localparam int IdxW       = 6;
  localparam int MaxEntries = MaxSize * MaxSize;
  localparam int AddrW      = 12;
  localparam int CntW       = 13;
  localparam int DataW      = 32;
  localparam int FifoDepth  = 4;
  localparam int FifoPtrW   = 2;

  // one word from the front to the back: a store write, tagged when it ends a load
  typedef struct packed {
    logic             last;
    logic [SizeW-1:0] size;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] k;
    logic [DataW-1:0] l;
  } load_word_t;

endpackage

// ----- hdl/hsic_fifo.sv -----
// Short queue of load words between the front and the back.
module hsic_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  hsic_pkg::load_word_t wdata_i,
  output logic                full_o,
  input  logic                rd_i,
  output hsic_pkg::load_word_t rdata_o,
  output logic                empty_o
);

  hsic_pkg::load_word_t mem_q [hsic_pkg::FifoDepth];
  logic [hsic_pkg::FifoPtrW:0] wptr_q, rptr_q;

  assign empty_o = (wptr_q == rptr_q);
  assign full_o  = (wptr_q[hsic_pkg::FifoPtrW] != rptr_q[hsic_pkg::FifoPtrW]) &&
                   (wptr_q[hsic_pkg::FifoPtrW-1:0] == rptr_q[hsic_pkg::FifoPtrW-1:0]);
  assign rdata_o = mem_q[rptr_q[hsic_pkg::FifoPtrW-1:0]];

  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) begin
      mem_q[wptr_q[hsic_pkg::FifoPtrW-1:0]] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      if (wr_i && !full_o) wptr_q <= wptr_q + 1'b1;
      if (rd_i && !empty_o) rptr_q <= rptr_q + 1'b1;
    end
  end

  a_not_full_and_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(full_o && empty_o)) else $error("fifo both full and empty");

endmodule

// ----- hdl/hsic_front.sv -----
// Front end: size register, load counter and tagging of the word that ends a load.
module hsic_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [hsic_pkg::SizeW-1:0]     cfg_wdata_i,
  input  logic                           push_i,
  output logic                           full_o,
  input  logic signed [hsic_pkg::DataW-1:0] k_value_i,
  input  logic signed [hsic_pkg::DataW-1:0] l_value_i,
  output logic                           q_wr_o,
  output hsic_pkg::load_word_t           q_word_o,
  input  logic                           q_full_i
);

  logic [hsic_pkg::SizeW-1:0] size_q, n_eff;
  logic [hsic_pkg::CntW-1:0]  count_q, count_nx, nsq;
  logic                       accept, last;

  always_comb begin
    if (size_q < hsic_pkg::SizeW'(2)) n_eff = hsic_pkg::SizeW'(2);
    else if (size_q > hsic_pkg::SizeW'(hsic_pkg::MaxSize)) n_eff = hsic_pkg::SizeW'(hsic_pkg::MaxSize);
    else n_eff = size_q;
  end

  assign nsq      = {6'd0, n_eff} * {6'd0, n_eff};
  assign count_nx = count_q + 1'b1;
  assign last     = (count_nx >= nsq);
  assign accept   = push_i && !q_full_i;
  assign full_o   = q_full_i;

  assign q_wr_o         = accept;
  assign q_word_o.last  = last;
  assign q_word_o.size  = n_eff;
  assign q_word_o.addr  = count_q[hsic_pkg::AddrW-1:0];
  assign q_word_o.k     = k_value_i;
  assign q_word_o.l     = l_value_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= hsic_pkg::SizeW'(2);
      count_q <= '0;
    end else begin
      if (cfg_we_i) size_q <= cfg_wdata_i;
      if (accept) count_q <= last ? '0 : count_nx;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < hsic_pkg::CntW'(hsic_pkg::MaxEntries)) else $error("load count past store");
  a_last_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last) |=> (count_q == '0)) else $error("load count did not restart");

endmodule

// ----- hdl/hsic_back.sv -----
// Back end: stores, sweep for trace and sums, final products, divider and result register.
module hsic_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hsic_pkg::load_word_t q_word_i,
  input  logic                 q_empty_i,
  output logic                 q_rd_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output logic signed [63:0]   hsic_value_o,
  output logic                 saturated_o
);

  localparam int NumW = 96;
  localparam int DW   = 24;

  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_SWEEP  = 4'd1;
  localparam logic [3:0] S_DRAIN  = 4'd2;
  localparam logic [3:0] S_SUMS   = 4'd3;
  localparam logic [3:0] S_SDRAIN = 4'd4;
  localparam logic [3:0] S_MUL1   = 4'd5;
  localparam logic [3:0] S_MUL2   = 4'd6;
  localparam logic [3:0] S_ADD    = 4'd7;
  localparam logic [3:0] S_SIGN   = 4'd8;
  localparam logic [3:0] S_DIV    = 4'd9;
  localparam logic [3:0] S_ROUND  = 4'd10;

  logic [3:0] state_q;

  logic [hsic_pkg::DataW-1:0] k_mem [hsic_pkg::MaxEntries];
  logic [hsic_pkg::DataW-1:0] l_mem [hsic_pkg::MaxEntries];
  logic signed [37:0] ck_mem [hsic_pkg::MaxSize];
  logic signed [37:0] cl_mem [hsic_pkg::MaxSize];
  logic signed [37:0] rk_mem [hsic_pkg::MaxSize];
  logic signed [37:0] rl_mem [hsic_pkg::MaxSize];

  logic [hsic_pkg::SizeW-1:0] n_q, nm1;
  logic [hsic_pkg::CntW-1:0]  nsq_q;
  logic [11:0]                nm1sq_q;
  logic [hsic_pkg::IdxW-1:0]  i_q, j_q, m_q, col_raddr;
  logic [hsic_pkg::AddrW-1:0] addr_q, taddr_q;

  logic signed [31:0] kd_q, ld_q, ltd_q;
  logic signed [37:0] ck_rd_q, cl_rd_q, rk_rd_q, rl_rd_q;
  logic signed [37:0] ck_new, cl_new, rk_new, rl_new;
  logic signed [37:0] rk_acc_q, rl_acc_q;

  logic                       s1_v_q, s2_v_q, p1_v_q, p2_v_q;
  logic [hsic_pkg::IdxW-1:0]  s1_i_q, s1_j_q;
  logic                       s1_first_q, s1_jfirst_q, s1_jlast_q;
  logic signed [63:0]         prod_q;
  logic signed [75:0]         a_q, pm1_q, pm2_q;
  logic signed [83:0]         bc_q;
  logic signed [44:0]         sk_q, sl_q;
  logic signed [89:0]         pa_q;
  logic signed [91:0]         pb_q;
  logic signed [68:0]         ps0_q;
  logic signed [66:0]         ps1_q;
  logic signed [NumW-1:0]     part_q, num_q;
  logic [DW-1:0]              d_q, rem_q;
  logic [NumW-1:0]            quo_q, quo_rnd;
  logic [6:0]                 cnt_q;
  logic                       neg_q;
  logic [DW:0]                trial;
  logic                       fit, rnd, sat;
  logic [63:0]                val;
  logic                       out_valid_q;
  logic signed [63:0]         out_val_q;
  logic                       out_sat_q;
  logic                       pop_word, jlast, ilast;
  logic [hsic_pkg::SizeW-1:0] wsize_m1;

  assign nm1       = n_q - 1'b1;
  assign wsize_m1  = q_word_i.size - 1'b1;
  assign pop_word  = (state_q == S_LOAD) && !q_empty_i;
  assign q_rd_o    = pop_word;
  assign jlast     = ({1'b0, j_q} == nm1);
  assign ilast     = ({1'b0, i_q} == nm1);
  assign col_raddr = (state_q == S_SUMS) ? m_q : j_q;

  // stores: one write port, reads registered
  always_ff @(posedge clk_i) begin
    if (pop_word) begin
      k_mem[q_word_i.addr] <= q_word_i.k;
      l_mem[q_word_i.addr] <= q_word_i.l;
    end
    kd_q  <= k_mem[addr_q];
    ld_q  <= l_mem[addr_q];
    ltd_q <= l_mem[taddr_q];
  end

  // first row starts the column sums from zero
  assign ck_new = (s1_first_q ? 38'sd0 : ck_rd_q) + 38'(kd_q);
  assign cl_new = (s1_first_q ? 38'sd0 : cl_rd_q) + 38'(ld_q);
  assign rk_new = (s1_jfirst_q ? 38'sd0 : rk_acc_q) + 38'(kd_q);
  assign rl_new = (s1_jfirst_q ? 38'sd0 : rl_acc_q) + 38'(ld_q);

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      ck_mem[s1_j_q] <= ck_new;
      cl_mem[s1_j_q] <= cl_new;
    end
    ck_rd_q <= ck_mem[col_raddr];
    cl_rd_q <= cl_mem[col_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q && s1_jlast_q) begin
      rk_mem[s1_i_q] <= rk_new;
      rl_mem[s1_i_q] <= rl_new;
    end
    rk_rd_q <= rk_mem[m_q];
    rl_rd_q <= rl_mem[m_q];
  end

  // datapath registers without reset
  always_ff @(posedge clk_i) begin
    s1_i_q      <= i_q;
    s1_j_q      <= j_q;
    s1_first_q  <= (i_q == '0);
    s1_jfirst_q <= (j_q == '0);
    s1_jlast_q  <= jlast;
    if (s1_v_q) begin
      rk_acc_q <= rk_new;
      rl_acc_q <= rl_new;
    end
    prod_q <= kd_q * ltd_q;
    pm1_q  <= ck_rd_q * rl_rd_q;
    pm2_q  <= rk_rd_q * cl_rd_q;
  end

  assign trial   = {rem_q, quo_q[NumW-1]};
  assign fit     = (trial >= {1'b0, d_q});
  assign rnd     = ({rem_q, 1'b0} >= {1'b0, d_q});
  assign quo_rnd = quo_q + NumW'(rnd);

  always_comb begin
    if (!neg_q) begin
      sat = |quo_rnd[NumW-1:63];
      val = sat ? 64'h7FFF_FFFF_FFFF_FFFF : quo_rnd[63:0];
    end else begin
      sat = (|quo_rnd[NumW-1:64]) || (quo_rnd[63] && (|quo_rnd[62:0]));
      val = sat ? 64'h8000_0000_0000_0000 : (64'd0 - quo_rnd[63:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      p1_v_q      <= 1'b0;
      p2_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
      n_q         <= hsic_pkg::SizeW'(2);
      nsq_q       <= '0;
      nm1sq_q     <= '0;
      i_q         <= '0;
      j_q         <= '0;
      m_q         <= '0;
      addr_q      <= '0;
      taddr_q     <= '0;
      cnt_q       <= '0;
      a_q         <= '0;
      bc_q        <= '0;
      sk_q        <= '0;
      sl_q        <= '0;
    end else begin
      s1_v_q <= (state_q == S_SWEEP);
      s2_v_q <= s1_v_q;
      p1_v_q <= (state_q == S_SUMS);
      p2_v_q <= p1_v_q;
      if (s2_v_q) a_q <= a_q + 76'(prod_q);
      if (p1_v_q) begin
        sk_q <= sk_q + 45'(rk_rd_q);
        sl_q <= sl_q + 45'(rl_rd_q);
      end
      if (p2_v_q) bc_q <= bc_q + 84'(pm1_q) + 84'(pm2_q);
      if (pop_i && out_valid_q) out_valid_q <= 1'b0;

      case (state_q)
        S_LOAD: begin
          if (pop_word && q_word_i.last) begin
            n_q     <= q_word_i.size;
            nsq_q   <= {6'd0, q_word_i.size} * {6'd0, q_word_i.size};
            nm1sq_q <= {6'd0, wsize_m1[5:0]} * {6'd0, wsize_m1[5:0]};
            i_q     <= '0;
            j_q     <= '0;
            addr_q  <= '0;
            taddr_q <= '0;
            a_q     <= '0;
            state_q <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          addr_q <= addr_q + 1'b1;
          if (jlast) begin
            j_q     <= '0;
            i_q     <= i_q + 1'b1;
            taddr_q <= hsic_pkg::AddrW'(i_q) + 1'b1;
            if (ilast) state_q <= S_DRAIN;
          end else begin
            j_q     <= j_q + 1'b1;
            taddr_q <= taddr_q + hsic_pkg::AddrW'(n_q);
          end
        end
        S_DRAIN: begin
          if (!s1_v_q && !s2_v_q) begin
            m_q     <= '0;
            sk_q    <= '0;
            sl_q    <= '0;
            bc_q    <= '0;
            state_q <= S_SUMS;
          end
        end
        S_SUMS: begin
          m_q <= m_q + 1'b1;
          if ({1'b0, m_q} == nm1) state_q <= S_SDRAIN;
        end
        S_SDRAIN: begin
          if (!p1_v_q && !p2_v_q) state_q <= S_MUL1;
        end
        S_MUL1: begin
          pa_q    <= a_q * $signed({1'b0, nsq_q});
          pb_q    <= bc_q * $signed({1'b0, n_q});
          ps0_q   <= sk_q * $signed({1'b0, sl_q[22:0]});
          d_q     <= {11'd0, nsq_q} * {12'd0, nm1sq_q};
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          ps1_q   <= sk_q * $signed(sl_q[44:23]);
          part_q  <= NumW'(pa_q) - NumW'(pb_q) + NumW'(ps0_q);
          state_q <= S_ADD;
        end
        S_ADD: begin
          num_q   <= part_q + (NumW'(ps1_q) <<< 23);
          state_q <= S_SIGN;
        end
        S_SIGN: begin
          neg_q   <= num_q[NumW-1];
          quo_q   <= num_q[NumW-1] ? NumW'(-num_q) : NumW'(num_q);
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          // restoring divide, one quotient bit a cycle
          rem_q <= fit ? DW'(trial - {1'b0, d_q}) : trial[DW-1:0];
          quo_q <= {quo_q[NumW-2:0], fit};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 7'(NumW - 1)) state_q <= S_ROUND;
        end
        S_ROUND: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            out_val_q   <= val;
            out_sat_q   <= sat;
            state_q     <= S_LOAD;
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign empty_o      = !out_valid_q;
  assign hsic_value_o = out_val_q;
  assign saturated_o  = out_sat_q;

  a_result_from_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_ROUND)) else $error("result without round step");
  a_load_pipes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD) |-> (!s2_v_q && !p2_v_q)) else $error("sweep busy while loading");

endmodule

// ----- hdl/hsic_centered_trace.sv -----
// Top level: front end, word queue and back end of the centered-trace block.
// Loading takes one word per cycle while full_o is low; words pass the queue to the stores.
// After the word that ends a load, the back end works out the result in these steps:
// a sweep over the stores (one element per cycle), a pass over the sums, and a 96-step divider.
// During that compute the 4-entry queue fills and full_o holds off further pushes.
// Reset clears counters, sets the size to 2 and empties the output; the stores are not cleared.
module hsic_centered_trace (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [hsic_pkg::SizeW-1:0]  cfg_wdata_i,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic signed [31:0]          k_value_i,
  input  logic signed [31:0]          l_value_i,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic signed [63:0]          hsic_value_o,
  output logic                        saturated_o
);

  hsic_pkg::load_word_t wr_word, rd_word;
  logic q_wr, q_full, q_rd, q_empty;

  hsic_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push_i),
    .full_o      (full_o),
    .k_value_i   (k_value_i),
    .l_value_i   (l_value_i),
    .q_wr_o      (q_wr),
    .q_word_o    (wr_word),
    .q_full_i    (q_full)
  );

  hsic_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (wr_word),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .rdata_o (rd_word),
    .empty_o (q_empty)
  );

  hsic_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_word_i     (rd_word),
    .q_empty_i    (q_empty),
    .q_rd_o       (q_rd),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .hsic_value_o (hsic_value_o),
    .saturated_o  (saturated_o)
  );

endmodule
